// ===== sv/gfelp_pkg.sv =====
`default_nettype none
package gfelp_pkg;

  localparam int LOC_W  = 8;
  localparam int COEF_W = 8;
  localparam int DEG_W  = 5;
  localparam int CFG_W  = 8;

  localparam logic [CFG_W-1:0] FIELD_POLY_RESET = 8'h1D;

  localparam int PARITY_SYMBOLS_DEF = 16;
  localparam int SYMBOL_BITS_DEF    = 8;

  typedef struct packed {
    logic update;
    logic shift;
  } gfelp_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/gfelp_loc_if.sv =====
`default_nettype none
interface gfelp_loc_if
  import gfelp_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [LOC_W-1:0] locator;
  logic             final_locator;

  modport source (output valid, output locator, output final_locator, input ready);
  modport sink   (input valid, input locator, input final_locator, output ready);
endinterface
`default_nettype wire

// ===== sv/gfelp_coef_if.sv =====
`default_nettype none
interface gfelp_coef_if
  import gfelp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic [DEG_W-1:0]  degree;
  logic              last_coeff;

  modport source (output valid, output coefficient, output degree, output last_coeff,
                  input ready);
  modport sink   (input valid, input coefficient, input degree, input last_coeff,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/gf_erasure_locator_poly_core.sv =====
`default_nettype none
// Reed-Solomon erasure locator builder over GF(2^SYMBOL_BITS). Each locator beat
// multiplies the held polynomial by (1 + L*x): a chain of PARITY_SYMBOLS+1 cells,
// each with its own field multiplier, updates every coefficient at once, so
// non-final locators are taken one per cycle. The beat marked final_locator is
// applied the same way and then the chain shifts its coefficients out toward the
// constant-term cell, one output beat per cycle while the sink is ready, degree 0
// first and last_coeff on degree PARITY_SYMBOLS. During those PARITY_SYMBOLS+1
// beats the locator channel is held off; the chain comes back holding
// the polynomial 1. field_poly_low sets the low bits of the reduction polynomial
// (default 0x1D, i.e. 0x11D); the user writes it only while idle (unenforced).
module gf_erasure_locator_poly_core
  import gfelp_pkg::*;
#(
  parameter int PARITY_SYMBOLS = PARITY_SYMBOLS_DEF,
  parameter int SYMBOL_BITS    = SYMBOL_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  gfelp_loc_if.sink             locators,
  gfelp_coef_if.source          coefficients,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int NCELL = PARITY_SYMBOLS + 1;
  localparam int CNT_W = $clog2(NCELL);
  localparam logic [CNT_W-1:0] LAST_DEG = CNT_W'(PARITY_SYMBOLS);

  logic [CFG_W-1:0]       field_poly_low;
  logic                   emitting;
  logic [CNT_W-1:0]       cnt;
  gfelp_ctrl_t            ctrl;
  logic [SYMBOL_BITS-1:0] loc;
  logic [SYMBOL_BITS-1:0] red;
  logic [SYMBOL_BITS-1:0] fill;
  logic [SYMBOL_BITS-1:0] coef [NCELL];
  logic                   in_fire;

  assign in_fire     = locators.valid && locators.ready;
  assign ctrl.update = in_fire;
  assign ctrl.shift  = coefficients.valid && coefficients.ready;
  assign loc         = SYMBOL_BITS'(locators.locator);
  assign red         = SYMBOL_BITS'(field_poly_low);
  assign fill        = SYMBOL_BITS'(cnt == '0);

  assign locators.ready           = !emitting;
  assign coefficients.valid       = emitting;
  assign coefficients.coefficient = COEF_W'(coef[0]);
  assign coefficients.degree      = DEG_W'(cnt);
  assign coefficients.last_coeff  = (cnt == LAST_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly_low <= FIELD_POLY_RESET;
    end else if (cfg_we) begin
      field_poly_low <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      cnt      <= '0;
    end else if (in_fire && locators.final_locator) begin
      emitting <= 1'b1;
      cnt      <= '0;
    end else if (ctrl.shift) begin
      if (cnt == LAST_DEG) begin
        emitting <= 1'b0;
        cnt      <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  for (genvar d = 0; d < NCELL; d++) begin : g_cell
    logic [SYMBOL_BITS-1:0] prev;
    logic [SYMBOL_BITS-1:0] above;
    if (d == 0) begin : g_lo
      assign prev = '0;
    end else begin : g_mid
      assign prev = coef[d-1];
    end
    if (d == NCELL - 1) begin : g_top
      assign above = fill;
    end else begin : g_below
      assign above = coef[d+1];
    end
    gfelp_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .RESET_ONE   (d == 0)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .loc   (loc),
      .red   (red),
      .prev  (prev),
      .above (above),
      .coef  (coef[d])
    );
  end

`ifndef SYNTHESIS
  a_final_starts_emit: assert property (@(posedge clk) disable iff (rst)
    in_fire && locators.final_locator |=> emitting && cnt == '0)
    else $error("final locator did not start emission at degree 0");

  a_end_restores_one: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift && cnt == LAST_DEG |=> !emitting && coef[0] == SYMBOL_BITS'(1))
    else $error("polynomial not returned to one after emission");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !emitting |-> cnt == '0)
    else $error("degree counter nonzero while idle");

  a_no_update_in_emit: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.update && ctrl.shift))
    else $error("update and shift in the same cycle");
`endif

endmodule
`default_nettype wire

// ===== sv/gfelp_cell.sv =====
`default_nettype none
module gfelp_cell
  import gfelp_pkg::*;
#(
  parameter int   SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter logic RESET_ONE   = 1'b0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gfelp_ctrl_t            ctrl,
  input  wire logic [SYMBOL_BITS-1:0] loc,
  input  wire logic [SYMBOL_BITS-1:0] red,
  input  wire logic [SYMBOL_BITS-1:0] prev,
  input  wire logic [SYMBOL_BITS-1:0] above,
  output logic      [SYMBOL_BITS-1:0] coef
);

  logic [SYMBOL_BITS-1:0] prod;
  logic [SYMBOL_BITS-1:0] mul_a;

  always_comb begin
    prod  = '0;
    mul_a = loc;
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      if (prev[i]) begin
        prod = prod ^ mul_a;
      end
      mul_a = {mul_a[SYMBOL_BITS-2:0], 1'b0} ^ (mul_a[SYMBOL_BITS-1] ? red : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= SYMBOL_BITS'(RESET_ONE);
    end else if (ctrl.update) begin
      coef <= coef ^ prod;
    end else if (ctrl.shift) begin
      coef <= above;
    end
  end

endmodule
`default_nettype wire
